[rtl/gge_pkg.sv]
// Package for the GTP-U G-PDU encapsulator: queue entry type, command kinds,
// and the header and echo request byte tables. No dependencies.
package gge_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_REJ  = 2'd1;
  localparam logic [1:0] KIND_HDR  = 2'd2;
  localparam logic [1:0] KIND_ECHO = 2'd3;

  localparam logic [4:0] HDR_LAST_IDX  = 5'd16;
  localparam logic [4:0] ECHO_LAST_IDX = 5'd13;

  localparam logic [15:0] GTP_EXT_LEN = 16'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] aux;    // G-PDU length field or echo sequence number
  } gge_cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] glen,
                                          input logic [31:0] teid, input logic [5:0] qfi);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h34;
      4'd1:    b = 8'hff;
      4'd2:    b = glen[15:8];
      4'd3:    b = glen[7:0];
      4'd4:    b = teid[31:24];
      4'd5:    b = teid[23:16];
      4'd6:    b = teid[15:8];
      4'd7:    b = teid[7:0];
      4'd11:   b = 8'h85;
      4'd12:   b = 8'h01;
      4'd13:   b = 8'h10;
      4'd14:   b = {2'b00, qfi};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] echo_byte(input logic [3:0] idx, input logic [15:0] seq);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h32;
      4'd1:    b = 8'h01;
      4'd3:    b = 8'h06;
      4'd8:    b = seq[15:8];
      4'd9:    b = seq[7:0];
      4'd12:   b = 8'h0e;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/gge_front.sv]
// Front end: accepts input transactions, tracks the drop state and turns each
// transaction into a command for the back end. Depends on gge_pkg.
module gge_front import gge_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        upf_ready,
  input  logic        q_full,
  output logic        q_push,
  output gge_cmd_t    q_cmd
);

  logic dropping;
  logic dropping_next;
  logic acc;
  logic mode;
  logic first;
  logic [15:0] ilen;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;
  assign mode     = s_tuser[0];
  assign first    = s_tuser[1];
  assign ilen     = s_tdata[23:8];

  always_comb begin
    dropping_next = dropping;
    q_push        = 1'b0;
    q_cmd.kind    = KIND_PASS;
    q_cmd.data    = s_tdata[7:0];
    q_cmd.last    = s_tlast;
    q_cmd.aux     = ilen + GTP_EXT_LEN;
    if (acc) begin
      if (mode) begin
        q_push     = 1'b1;
        q_cmd.kind = KIND_ECHO;
        q_cmd.aux  = s_tdata[39:24];
      end else if (first) begin
        q_push = 1'b1;
        if (!upf_ready || ilen == 16'd0) begin
          q_cmd.kind    = KIND_REJ;
          dropping_next = !s_tlast;
        end else begin
          q_cmd.kind    = KIND_HDR;
          dropping_next = 1'b0;
        end
      end else if (dropping) begin
        if (s_tlast) dropping_next = 1'b0;
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropping <= 1'b0;
    end else begin
      dropping <= dropping_next;
    end
  end

endmodule

[rtl/gge_fifo.sv]
// Short command queue between front and back end.
// Depends on gge_pkg.
module gge_fifo import gge_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  gge_cmd_t wr_cmd,
  input  logic     pop,
  output gge_cmd_t rd_cmd,
  output logic     empty,
  output logic     full
);

  gge_cmd_t mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign empty  = (count == '0);
  assign full   = (count == (QAW+1)'(QDEPTH));
  assign rd_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/gge_back.sv]
// Back end: expands each queued command into output bytes through a
// registered output stage. Depends on gge_pkg.
module gge_back import gge_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  gge_cmd_t    cmd,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic [31:0] teid,
  input  logic [5:0]  qfi,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  logic [4:0] cnt;
  logic [4:0] last_idx;
  logic       step;
  logic       end_cmd;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic       stat_sel;

  assign step    = !q_empty && (!m_tvalid || m_tready);
  assign end_cmd = (cnt == last_idx);
  assign q_pop   = step && end_cmd;

  always_comb begin
    last_idx = 5'd0;
    byte_sel = cmd.data;
    last_sel = cmd.last;
    stat_sel = 1'b0;
    case (cmd.kind)
      KIND_PASS: begin
      end
      KIND_REJ: begin
        byte_sel = 8'h00;
        last_sel = 1'b1;
        stat_sel = 1'b1;
      end
      KIND_HDR: begin
        last_idx = HDR_LAST_IDX;
        if (!end_cmd) begin
          byte_sel = hdr_byte(cnt[3:0], cmd.aux, teid, qfi);
          last_sel = 1'b0;
        end
      end
      KIND_ECHO: begin
        last_idx = ECHO_LAST_IDX;
        byte_sel = echo_byte(cnt[3:0], cmd.aux);
        last_sel = end_cmd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (step) begin
        m_tvalid <= 1'b1;
        cnt      <= end_cmd ? 5'd0 : cnt + 5'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= byte_sel;
      m_tlast <= last_sel;
      m_tuser <= stat_sel;
    end
  end

endmodule

[rtl/gtpu_gpdu_encapsulator.sv]
// Channel   | Signals                         | Direction
// input     | s_tvalid s_tready s_tdata s_tuser s_tlast | in
// output    | m_tvalid m_tready m_tdata m_tuser m_tlast | out
// config    | cfg_we cfg_index cfg_data      | in
// Payload bytes pass at one per cycle unless the queue or output stalls; a
// G-PDU first byte gives 16 header bytes plus the byte, an echo request 14
// bytes, a rejection 1. Output rate is set by the back end byte counter; a
// 4-entry command queue lets the input side run ahead. Output bytes pass
// through the command queue and then the registered output stage.
// Synchronous reset clears the config registers, drop state, queue and output valid.
// Depends on gge_pkg, gge_front, gge_fifo, gge_back.
module gtpu_gpdu_encapsulator import gge_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_byte[7:0], inner_length[23:8], echo_seq[39:24]
  input  logic [1:0]  s_tuser,   // mode[0], first_byte[1]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tuser,   // status[0]
  output logic        m_tlast,   // out_last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] REG_TEID = 2'd0;
  localparam logic [1:0] REG_QFI  = 2'd1;
  localparam logic [1:0] REG_UPF  = 2'd2;

  logic [31:0] teid;
  logic [5:0]  qfi;
  logic        upf_ready;
  gge_cmd_t    push_cmd;
  gge_cmd_t    head_cmd;
  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      teid      <= '0;
      qfi       <= '0;
      upf_ready <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEID: teid      <= cfg_data;
        REG_QFI:  qfi       <= cfg_data[5:0];
        REG_UPF:  upf_ready <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gge_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .upf_ready (upf_ready),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  gge_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  gge_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (pop),
    .teid     (teid),
    .qfi      (qfi),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[rtl/gge_checker.sv]
// Port-level checker for the encapsulator, bound to the top level.
// Depends on gtpu_gpdu_encapsulator port names only.
module gge_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'h00)
    else $error("rejection transaction malformed");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind gtpu_gpdu_encapsulator gge_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[tb/tb_gtpu_gpdu_encapsulator.sv]
// Self-checking testbench for gtpu_gpdu_encapsulator: a directed table, then random
// packets under three idle mixes and one long output hold. Needs only the RTL.
`timescale 1ns / 1ps

module tb_gtpu_gpdu_encapsulator;

  localparam logic       MODE_GPDU      = 1'b0;
  localparam logic       MODE_ECHO      = 1'b1;
  localparam logic       ST_OK          = 1'b0;
  localparam logic       ST_REJECTED    = 1'b1;
  localparam logic [1:0] REG_TUNNEL_ID  = 2'd0;
  localparam logic [1:0] REG_QOS_FLOW   = 2'd1;
  localparam logic [1:0] REG_UP_READY   = 2'd2;

  localparam logic [7:0] GTPU_FLAGS_EXT  = 8'h34;
  localparam logic [7:0] GTPU_MSG_GPDU   = 8'hff;
  localparam logic [7:0] GTPU_FLAGS_ECHO = 8'h32;
  localparam logic [7:0] GTPU_MSG_ECHO   = 8'h01;
  localparam logic [7:0] GTPU_ECHO_LEN   = 8'h06;
  localparam logic [7:0] EXT_PDU_SESSION = 8'h85;
  localparam logic [7:0] EXT_LEN_ONE     = 8'h01;
  localparam logic [7:0] PDU_TYPE_UL     = 8'h10;
  localparam logic [7:0] IE_RECOVERY     = 8'h0e;
  localparam logic [15:0] EXT_HDR_BYTES  = 16'd8;

  localparam int CFG_RESET       = 0;
  localparam int CFG_ALL_ONES    = 1;
  localparam int CFG_ALL_ZEROS   = 2;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASE_ITEMS     = 34;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] ilen;
    logic [15:0] seq;
  } gtp_item_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       last;
    logic       status;
  } gtp_out_t;

  typedef struct packed {
    logic [1:0] cfg_set;
    gtp_item_t  it;
    logic       typed;
    gtp_out_t   want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // data_byte[7:0], inner_length[23:8], echo_seq[39:24]
  logic [1:0]  s_tuser;   // mode[0], first_byte[1]
  logic        s_tlast;   // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte[7:0]
  logic        m_tuser;   // status[0]
  logic        m_tlast;   // out_last
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  gtpu_gpdu_encapsulator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gtp_out_t    expected_bytes [$];
  gtp_out_t    head;
  dir_row_t    dir_rows [$];
  logic [31:0] exp_teid;
  logic [5:0]  exp_qfi;
  logic        exp_up_ready;
  logic        drop_active;
  int          mismatches = 0;
  int          send_idle_pct = 38;
  int          recv_idle_pct = 59;
  int          hold_count;
  int          quiet_cycles;
  bit          hold_output = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: %s mismatch, expected %02h got %02h", $time, what, want, got);
    mismatches++;
  endtask

  // Computes the bytes one input transaction produces; state is always updated.
  task automatic encap_predict(input gtp_item_t it, input bit push);
    logic [15:0] glen;
    logic [7:0]  hb [16];
    gtp_out_t    res [$];
    hb = '{default: 8'h00};
    if (it.mode == MODE_ECHO) begin
      hb[0]  = GTPU_FLAGS_ECHO;
      hb[1]  = GTPU_MSG_ECHO;
      hb[3]  = GTPU_ECHO_LEN;
      hb[8]  = it.seq[15:8];
      hb[9]  = it.seq[7:0];
      hb[12] = IE_RECOVERY;
      for (int i = 0; i < 14; i++) res.push_back('{hb[i], (i == 13), ST_OK});
    end else if (it.first) begin
      if (!exp_up_ready || it.ilen == 16'd0) begin
        res.push_back('{8'h00, 1'b1, ST_REJECTED});
        drop_active = !it.last;
      end else begin
        drop_active = 1'b0;
        glen   = it.ilen + EXT_HDR_BYTES;
        hb[0]  = GTPU_FLAGS_EXT;
        hb[1]  = GTPU_MSG_GPDU;
        hb[2]  = glen[15:8];
        hb[3]  = glen[7:0];
        hb[4]  = exp_teid[31:24];
        hb[5]  = exp_teid[23:16];
        hb[6]  = exp_teid[15:8];
        hb[7]  = exp_teid[7:0];
        hb[11] = EXT_PDU_SESSION;
        hb[12] = EXT_LEN_ONE;
        hb[13] = PDU_TYPE_UL;
        hb[14] = {2'b00, exp_qfi};
        for (int i = 0; i < 16; i++) res.push_back('{hb[i], 1'b0, ST_OK});
        res.push_back('{it.data, it.last, ST_OK});
      end
    end else if (drop_active) begin
      if (it.last) drop_active = 1'b0;
    end else begin
      res.push_back('{it.data, it.last, ST_OK});
    end
    if (push) foreach (res[i]) expected_bytes.push_back(res[i]);
  endtask

  // Entered and left at a falling edge.
  task automatic send_item(input gtp_item_t it, input bit typed, input gtp_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.seq, it.ilen, it.data};
    s_tuser  <= {it.first, it.mode};
    s_tlast  <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encap_predict(it, !typed);
    if (typed) expected_bytes.push_back(want);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_cfg(input logic [31:0] teid, input logic [5:0] qfi, input logic upr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TUNNEL_ID;
    cfg_data  <= teid;
    @(negedge clk);
    cfg_index <= REG_QOS_FLOW;
    cfg_data  <= {26'd0, qfi};
    @(negedge clk);
    cfg_index <= REG_UP_READY;
    cfg_data  <= {31'd0, upr};
    @(negedge clk);
    cfg_we <= 1'b0;
    exp_teid     = teid;
    exp_qfi      = qfi;
    exp_up_ready = upr;
  endtask

  function automatic dir_row_t dir_row(input int cs, input logic mode, input logic [7:0] data,
                                       input logic first, input logic last,
                                       input logic [15:0] ilen, input logic [15:0] seq,
                                       input logic typed, input gtp_out_t want);
    dir_row_t r;
    r.cfg_set = cs[1:0];
    r.it      = '{mode, data, first, last, ilen, seq};
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  task automatic send_random_packet(inout int sent);
    gtp_item_t it;
    int        nbytes;
    int        pick;
    it.mode  = MODE_GPDU;
    it.data  = 8'($urandom);
    it.first = 1'($urandom_range(1));
    it.last  = 1'($urandom_range(1));
    it.ilen  = 16'($urandom);
    it.seq   = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.mode = MODE_ECHO;
      send_item(it, 1'b0, '0);
      sent++;
    end else if (pick < 22) begin
      send_item(it, 1'b0, '0);
      sent++;
    end else begin
      nbytes = $urandom_range(1, 6);
      pick   = $urandom_range(99);
      if (pick < 8) it.ilen = 16'd0;
      else if (pick >= 20) it.ilen = nbytes[15:0];
      for (int k = 0; k < nbytes; k++) begin
        it.first = (k == 0);
        it.last  = (k == nbytes - 1);
        it.data  = 8'($urandom);
        it.seq   = 16'($urandom);
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected transaction", 8'h00, m_tdata);
      end else begin
        head = expected_bytes.pop_front();
        if (m_tdata !== head.ob) report_mismatch("out_byte", head.ob, m_tdata);
        if (m_tlast !== head.last)
          report_mismatch("out_last", {7'd0, head.last}, {7'd0, m_tlast});
        if (m_tuser !== head.status)
          report_mismatch("status", {7'd0, head.status}, {7'd0, m_tuser});
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        m_tready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
        hold_output = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int cur_set;
    int sent;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    s_tlast      = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_TUNNEL_ID;
    cfg_data     = '0;
    exp_teid     = '0;
    exp_qfi      = '0;
    exp_up_ready = 1'b0;
    drop_active  = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: user plane down, so every first byte is rejected
    dir_rows.push_back(dir_row(CFG_RESET, MODE_GPDU, 8'haa, 1, 1, 16'd5, 16'h0000, 1,
                               '{8'h00, 1'b1, ST_REJECTED}));
    dir_rows.push_back(dir_row(CFG_RESET, MODE_GPDU, 8'h55, 1, 0, 16'd10, 16'h0000, 1,
                               '{8'h00, 1'b1, ST_REJECTED}));
    dir_rows.push_back(dir_row(CFG_RESET, MODE_GPDU, 8'h11, 0, 0, 16'd0, 16'h0000, 0, '0));
    dir_rows.push_back(dir_row(CFG_RESET, MODE_ECHO, 8'h00, 0, 1, 16'd0, 16'hffff, 0, '0));
    dir_rows.push_back(dir_row(CFG_RESET, MODE_GPDU, 8'h22, 0, 1, 16'd0, 16'h0000, 0, '0));
    dir_rows.push_back(dir_row(CFG_RESET, MODE_GPDU, 8'hff, 0, 0, 16'd0, 16'h0000, 1,
                               '{8'hff, 1'b0, ST_OK}));
    dir_rows.push_back(dir_row(CFG_RESET, MODE_GPDU, 8'h01, 0, 1, 16'd0, 16'h0000, 1,
                               '{8'h01, 1'b1, ST_OK}));
    // all registers at their maximum
    dir_rows.push_back(dir_row(CFG_ALL_ONES, MODE_GPDU, 8'h00, 1, 0, 16'd65527, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ONES, MODE_GPDU, 8'h5a, 0, 0, 16'd0, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ONES, MODE_GPDU, 8'hff, 0, 1, 16'd0, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ONES, MODE_GPDU, 8'hc3, 1, 0, 16'd0, 16'h0, 1,
                               '{8'h00, 1'b1, ST_REJECTED}));
    dir_rows.push_back(dir_row(CFG_ALL_ONES, MODE_GPDU, 8'h3c, 1, 1, 16'd1, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ONES, MODE_GPDU, 8'h80, 1, 1, 16'hfffc, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ONES, MODE_ECHO, 8'hff, 1, 0, 16'hffff, 16'h1234, 0, '0));
    // all registers at their minimum, user plane up
    dir_rows.push_back(dir_row(CFG_ALL_ZEROS, MODE_GPDU, 8'h00, 1, 1, 16'd1, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ZEROS, MODE_ECHO, 8'h00, 0, 0, 16'd0, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ZEROS, MODE_GPDU, 8'h7e, 1, 0, 16'd100, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ZEROS, MODE_GPDU, 8'h81, 0, 0, 16'd0, 16'h0, 0, '0));
    dir_rows.push_back(dir_row(CFG_ALL_ZEROS, MODE_GPDU, 8'he7, 0, 1, 16'd0, 16'h0, 0, '0));

    cur_set = CFG_RESET;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_set != cur_set) begin
        settle();
        cur_set = int'(dir_rows[i].cfg_set);
        if (cur_set == CFG_ALL_ONES) apply_cfg(32'hffff_ffff, 6'h3f, 1'b1);
        else apply_cfg(32'h0000_0000, 6'h00, 1'b1);
      end
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      apply_cfg($urandom, 6'($urandom_range(63)), ($urandom_range(9) != 0));
      if (phase == 2) hold_output = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_packet(sent);
    end

    settle();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/gge_pkg.sv
rtl/gge_front.sv
rtl/gge_fifo.sv
rtl/gge_back.sv
rtl/gtpu_gpdu_encapsulator.sv
rtl/gge_checker.sv
tb/tb_gtpu_gpdu_encapsulator.sv
